// ===== hw/rtl/mdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Magnetic dipole field package
// Shared constants, word types, pipeline carry types and normalizing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mdf_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int FIELD_FRAC_BITS = 40;
  localparam int SQRT_STEPS      = 31;
  localparam int DIV_STEPS       = 33;
  localparam int UQ_STEPS        = 31;
  localparam int LATENCY         = 90;
  localparam int XOFS            = FIELD_FRAC_BITS - 70 + 3 * COORD_FRAC_BITS - 63;

  typedef enum logic [2:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_POS_Z,
    REG_MOM_X,
    REG_MOM_Y,
    REG_MOM_Z,
    REG_GAIN
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic               saturated;
    logic               singular;
  } field_t;

  typedef struct packed {
    logic [2:0][29:0]  e;
    logic [2:0]        neg;
    logic signed [5:0] s;
    logic              sing;
    logic [61:0]       r2;
    logic [34:0]       rem;
    logic [30:0]       root;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][29:0]  e;
    logic [2:0]        neg;
    logic signed [5:0] s;
    logic              sing;
    logic [30:0]       re;
    logic [31:0]       mg;
    logic signed [7:0] eg;
    logic              gz;
  } pc_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic signed [5:0] s;
    logic              sing;
    logic [30:0]       re;
    logic [2:0][31:0]  urem;
    logic [2:0][30:0]  uq;
    logic [31:0]       m3;
    logic signed [7:0] e3;
    logic [32:0]       rrem;
    logic [32:0]       rq;
    logic [31:0]       mg;
    logic signed [7:0] eg;
    logic              gz;
  } div_t;

  typedef struct packed {
    logic signed [5:0] s;
    logic              sing;
    logic signed [7:0] e3;
    logic signed [7:0] eg;
    logic              gz;
    logic [31:0]       mp;
    logic signed [7:0] ep;
  } late_t;

  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [31:0] norm32(input logic [63:0] v, input logic [6:0] n);
    logic [63:0] t;
    if (n > 7'd32) t = v >> (n - 7'd32);
    else t = v << (7'd32 - n);
    return t[31:0];
  endfunction

  function automatic logic signed [7:0] expo(input logic [6:0] n);
    return $signed({1'b0, n}) - 8'sd32;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/magnetic_dipole_field.sv =====
// ----------------------------------------------------------------------------
// Magnetic dipole field evaluator
// Computes B = G/r^3 * (3(m.u)u - m) for each point in a fixed-latency pipeline.
// ----------------------------------------------------------------------------
// A point is taken in every cycle in which start is high; busy is never raised.
// Each point yields one result word, marked by done_o for one cycle, in order.
// The receiver cannot hold a result word off, so it must take each word in the
// cycle in which done_o is high. The pipeline holds the 31-step square root and
// the 33-step reciprocal division, one step per pipeline stage. The user must
// write registers through the APB port only while no point is in flight; the
// block itself does not enforce this.
`default_nettype none

module magnetic_dipole_field (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire mdf_pkg::point_t point_i,
  output      logic            done_o,
  output      mdf_pkg::field_t field_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [5:0]      paddr,
  input  wire logic [63:0]     pwdata,
  output      logic [63:0]     prdata,
  output      logic            pready
);

  logic signed [31:0] pos_q [3];
  logic signed [31:0] mom_q [3];
  logic [47:0]        gain_q;
  logic signed [31:0] pt [3];
  logic [mdf_pkg::LATENCY-1:0] vld_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign pt[0]  = point_i.point_x;
  assign pt[1]  = point_i.point_y;
  assign pt[2]  = point_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      mom_q[0] <= '0;
      mom_q[1] <= '0;
      mom_q[2] <= 32'sh4000_0000;
      gain_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (mdf_pkg::cfg_reg_e'(paddr[5:3]))
        mdf_pkg::REG_POS_X: pos_q[0] <= pwdata[31:0];
        mdf_pkg::REG_POS_Y: pos_q[1] <= pwdata[31:0];
        mdf_pkg::REG_POS_Z: pos_q[2] <= pwdata[31:0];
        mdf_pkg::REG_MOM_X: mom_q[0] <= pwdata[31:0];
        mdf_pkg::REG_MOM_Y: mom_q[1] <= pwdata[31:0];
        mdf_pkg::REG_MOM_Z: mom_q[2] <= pwdata[31:0];
        mdf_pkg::REG_GAIN:  gain_q   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mdf_pkg::cfg_reg_e'(paddr[5:3]))
      mdf_pkg::REG_POS_X: prdata = {32'h0, pos_q[0]};
      mdf_pkg::REG_POS_Y: prdata = {32'h0, pos_q[1]};
      mdf_pkg::REG_POS_Z: prdata = {32'h0, pos_q[2]};
      mdf_pkg::REG_MOM_X: prdata = {32'h0, mom_q[0]};
      mdf_pkg::REG_MOM_Y: prdata = {32'h0, mom_q[1]};
      mdf_pkg::REG_MOM_Z: prdata = {32'h0, mom_q[2]};
      mdf_pkg::REG_GAIN:  prdata = {16'h0, gain_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[mdf_pkg::LATENCY-2:0], start};
    end
  end

  // Displacement, magnitude and block normalization.
  logic signed [32:0] d1_q [3];
  logic [32:0]        a2_q [3];
  logic [2:0]         neg2_q, neg3_q, neg4_q, neg5_q, neg6_q, neg7_q;
  logic [32:0]        mx3_q, mx_c;
  logic [32:0]        a3_q [3];
  logic [32:0]        a4_q [3];
  logic [6:0]         bl4_c;
  logic signed [5:0]  s4_q, s5_q, s6_q, s7_q;
  logic               sing4_q, sing5_q, sing6_q, sing7_q;
  logic [5:0]         shamt_c;
  logic [29:0]        e5_d [3];
  logic [29:0]        e5_q [3];
  logic [29:0]        e6_q [3];
  logic [29:0]        e7_q [3];
  logic [59:0]        sq6_q [3];
  logic [61:0]        r2_7_q;

  always_comb begin
    mx_c = a2_q[0];
    if (a2_q[1] > mx_c) mx_c = a2_q[1];
    if (a2_q[2] > mx_c) mx_c = a2_q[2];
    bl4_c   = mdf_pkg::bit_len({31'b0, mx3_q});
    shamt_c = s4_q[5] ? 6'(-s4_q) : 6'(s4_q);
    for (int i = 0; i < 3; i++) begin
      if (s4_q[5]) e5_d[i] = 30'(a4_q[i] << shamt_c);
      else e5_d[i] = 30'(a4_q[i] >> shamt_c);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i]   <= $signed({pt[i][31], pt[i]}) - $signed({pos_q[i][31], pos_q[i]});
      a2_q[i]   <= d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
      neg2_q[i] <= d1_q[i][32];
      a3_q[i]   <= a2_q[i];
      a4_q[i]   <= a3_q[i];
      e5_q[i]   <= e5_d[i];
      e6_q[i]   <= e5_q[i];
      e7_q[i]   <= e6_q[i];
      sq6_q[i]  <= e5_q[i] * e5_q[i];
    end
    mx3_q   <= mx_c;
    neg3_q  <= neg2_q;
    neg4_q  <= neg3_q;
    neg5_q  <= neg4_q;
    neg6_q  <= neg5_q;
    neg7_q  <= neg6_q;
    s4_q    <= 6'(bl4_c - 7'd30);
    sing4_q <= (mx3_q == '0);
    s5_q    <= s4_q;
    s6_q    <= s5_q;
    s7_q    <= s6_q;
    sing5_q <= sing4_q;
    sing6_q <= sing5_q;
    sing7_q <= sing6_q;
    r2_7_q  <= 62'(sq6_q[0]) + 62'(sq6_q[1]) + 62'(sq6_q[2]);
  end

  // Digit-by-digit square root, one result bit per stage.
  mdf_pkg::sqrt_t sqrt_in;
  mdf_pkg::sqrt_t sq_q [mdf_pkg::SQRT_STEPS];

  always_comb begin
    sqrt_in      = '0;
    sqrt_in.e[0] = e7_q[0];
    sqrt_in.e[1] = e7_q[1];
    sqrt_in.e[2] = e7_q[2];
    sqrt_in.neg  = neg7_q;
    sqrt_in.s    = s7_q;
    sqrt_in.sing = sing7_q;
    sqrt_in.r2   = r2_7_q;
  end

  for (genvar t = 0; t < mdf_pkg::SQRT_STEPS; t++) begin : g_sqrt
    localparam int K = mdf_pkg::SQRT_STEPS - 1 - t;
    mdf_pkg::sqrt_t src, nxt;
    logic [34:0]    cur, trial;
    if (t == 0) begin : g_first
      assign src = sqrt_in;
    end else begin : g_rest
      assign src = sq_q[t-1];
    end
    always_comb begin
      nxt   = src;
      cur   = {src.rem[32:0], src.r2[2*K +: 2]};
      trial = {2'b00, src.root, 2'b01};
      if (cur >= trial) begin
        nxt.rem  = cur - trial;
        nxt.root = {src.root[29:0], 1'b1};
      end else begin
        nxt.rem  = cur;
        nxt.root = {src.root[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[t] <= nxt;
    end
  end

  // r^3 mantissa and gain mantissa.
  mdf_pkg::pc_t pc_q [6];
  mdf_pkg::pc_t pc_in, pc3_d;
  logic [61:0]       p2_q, p2c_q;
  logic [6:0]        bl2_q, blg_q, bl3_q;
  logic [31:0]       m2_q, m3_q;
  logic [62:0]       p3_q, p3c_q;
  logic signed [7:0] e3_q;

  always_comb begin
    pc_in      = '0;
    pc_in.e    = sq_q[mdf_pkg::SQRT_STEPS-1].e;
    pc_in.neg  = sq_q[mdf_pkg::SQRT_STEPS-1].neg;
    pc_in.s    = sq_q[mdf_pkg::SQRT_STEPS-1].s;
    pc_in.sing = sq_q[mdf_pkg::SQRT_STEPS-1].sing;
    pc_in.re   = sq_q[mdf_pkg::SQRT_STEPS-1].root;
    pc3_d      = pc_q[1];
    pc3_d.mg   = mdf_pkg::norm32({16'b0, gain_q}, blg_q);
    pc3_d.eg   = mdf_pkg::expo(blg_q);
    pc3_d.gz   = (gain_q == '0);
  end

  always_ff @(posedge clk_i) begin
    pc_q[0] <= pc_in;
    pc_q[1] <= pc_q[0];
    pc_q[2] <= pc3_d;
    pc_q[3] <= pc_q[2];
    pc_q[4] <= pc_q[3];
    pc_q[5] <= pc_q[4];
    p2_q    <= pc_in.re * pc_in.re;
    bl2_q   <= mdf_pkg::bit_len({2'b0, p2_q});
    blg_q   <= mdf_pkg::bit_len({16'b0, gain_q});
    p2c_q   <= p2_q;
    m2_q    <= mdf_pkg::norm32({2'b0, p2c_q}, bl2_q);
    p3_q    <= m2_q * pc_q[2].re;
    bl3_q   <= mdf_pkg::bit_len({1'b0, p3_q});
    p3c_q   <= p3_q;
    m3_q    <= mdf_pkg::norm32({1'b0, p3c_q}, bl3_q);
    e3_q    <= mdf_pkg::expo(bl3_q);
  end

  // Restoring division: 2^63 / M3 and the three e * 2^30 / r quotients.
  mdf_pkg::div_t div_in;
  mdf_pkg::div_t dv_q [mdf_pkg::DIV_STEPS];

  always_comb begin
    div_in      = '0;
    div_in.neg  = pc_q[5].neg;
    div_in.s    = pc_q[5].s;
    div_in.sing = pc_q[5].sing;
    div_in.re   = pc_q[5].re;
    for (int i = 0; i < 3; i++) begin
      div_in.urem[i] = {2'b00, pc_q[5].e[i]};
    end
    div_in.m3   = m3_q;
    div_in.e3   = e3_q;
    div_in.rrem = 33'h0_4000_0000;
    div_in.mg   = pc_q[5].mg;
    div_in.eg   = pc_q[5].eg;
    div_in.gz   = pc_q[5].gz;
  end

  for (genvar t = 0; t < mdf_pkg::DIV_STEPS; t++) begin : g_div
    mdf_pkg::div_t src, nxt;
    logic [32:0]   rcur;
    logic [31:0]   ucur [3];
    if (t == 0) begin : g_first
      assign src = div_in;
    end else begin : g_rest
      assign src = dv_q[t-1];
    end
    always_comb begin
      nxt  = src;
      rcur = {src.rrem[31:0], 1'b0};
      if (rcur >= {1'b0, src.m3}) begin
        nxt.rrem = rcur - {1'b0, src.m3};
        nxt.rq   = {src.rq[31:0], 1'b1};
      end else begin
        nxt.rrem = rcur;
        nxt.rq   = {src.rq[31:0], 1'b0};
      end
      for (int i = 0; i < 3; i++) begin
        if (t == 0) ucur[i] = src.urem[i];
        else ucur[i] = {src.urem[i][30:0], 1'b0};
        if (t < mdf_pkg::UQ_STEPS) begin
          if (ucur[i] >= {1'b0, src.re}) begin
            nxt.urem[i] = ucur[i] - {1'b0, src.re};
            nxt.uq[i]   = {src.uq[i][29:0], 1'b1};
          end else begin
            nxt.urem[i] = ucur[i];
            nxt.uq[i]   = {src.uq[i][29:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      dv_q[t] <= nxt;
    end
  end

  // Vector term, mantissa products and output scaling.
  mdf_pkg::div_t      dv;
  mdf_pkg::late_t     lt_q [12];
  mdf_pkg::late_t     lt_in, lt3_d;
  logic signed [31:0] u1_q [3];
  logic signed [31:0] u2_q [3];
  logic signed [31:0] u3_q [3];
  logic [63:0]        mpp1_q, mpp2_q;
  logic [6:0]         blp2_q;
  logic signed [63:0] mu2_q [3];
  logic signed [34:0] dot3_q;
  logic signed [66:0] du4_q [3];
  logic signed [39:0] w5_q [3];
  logic signed [39:0] t5_c [3];
  logic [39:0]        aw6_q [3];
  logic [39:0]        aw7_q [3];
  logic [5:0]         wf_q [7];
  logic [6:0]         blw7_q [3];
  logic [31:0]        mw8_q [3];
  logic signed [7:0]  ew8_q [3];
  logic [63:0]        pf9_q [3];
  logic [63:0]        pf10_q [3];
  logic [6:0]         blf10_q [3];
  logic signed [9:0]  xp9_q [3];
  logic signed [9:0]  xp10_q [3];
  logic signed [9:0]  xp9_c [3];
  logic signed [9:0]  sx_c;
  logic [31:0]        mf11_q [3];
  logic signed [9:0]  x11_q [3];
  logic [48:0]        lim_c [3];
  logic [48:0]        mag_c [3];
  logic [2:0]         sat_c;
  logic [47:0]        mag12_q [3];
  logic [2:0]         sat12_q;
  logic [47:0]        fld_c [3];
  logic               live_c;
  mdf_pkg::field_t    field_q;

  assign dv = dv_q[mdf_pkg::DIV_STEPS-1];

  always_comb begin
    lt_in      = '0;
    lt_in.s    = dv.s;
    lt_in.sing = dv.sing;
    lt_in.e3   = dv.e3;
    lt_in.eg   = dv.eg;
    lt_in.gz   = dv.gz;
    lt3_d      = lt_q[1];
    lt3_d.mp   = mdf_pkg::norm32(mpp2_q, blp2_q);
    lt3_d.ep   = mdf_pkg::expo(blp2_q);
    sx_c       = 10'(lt_q[7].s);
    for (int i = 0; i < 3; i++) begin
      t5_c[i]  = 40'(du4_q[i] >>> 30);
      xp9_c[i] = 10'(lt_q[7].ep) + 10'(lt_q[7].eg) - 10'(lt_q[7].e3) - sx_c - (sx_c <<< 1)
               + 10'(mdf_pkg::XOFS) + 10'(ew8_q[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim_c[i] = wf_q[5][i] ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
      sat_c[i] = 1'b0;
      if (x11_q[i] >= 10'sd17) mag_c[i] = lim_c[i] + 49'd1;
      else if (x11_q[i] >= 10'sd0) mag_c[i] = 49'(mf11_q[i]) << x11_q[i][4:0];
      else if (x11_q[i] <= -10'sd64) mag_c[i] = '0;
      else mag_c[i] = 49'(mf11_q[i] >> 6'(-x11_q[i]));
      if (mag_c[i] > lim_c[i]) begin
        mag_c[i] = lim_c[i];
        sat_c[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lt_q[0] <= lt_in;
    lt_q[1] <= lt_q[0];
    lt_q[2] <= lt3_d;
    for (int k = 3; k < 12; k++) begin
      lt_q[k] <= lt_q[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      wf_q[k] <= wf_q[k-1];
    end
    mpp1_q <= dv.mg * dv.rq;
    mpp2_q <= mpp1_q;
    blp2_q <= mdf_pkg::bit_len(mpp1_q);
    dot3_q <= 35'(mu2_q[0] >>> 30) + 35'(mu2_q[1] >>> 30) + 35'(mu2_q[2] >>> 30);
    for (int i = 0; i < 3; i++) begin
      u1_q[i]       <= dv.neg[i] ? -$signed({1'b0, dv.uq[i]}) : $signed({1'b0, dv.uq[i]});
      u2_q[i]       <= u1_q[i];
      u3_q[i]       <= u2_q[i];
      mu2_q[i]      <= mom_q[i] * u1_q[i];
      du4_q[i]      <= dot3_q * u3_q[i];
      w5_q[i]       <= t5_c[i] + (t5_c[i] <<< 1) - 40'(mom_q[i]);
      aw6_q[i]      <= w5_q[i][39] ? 40'(-w5_q[i]) : 40'(w5_q[i]);
      wf_q[0][i]    <= w5_q[i][39];
      wf_q[0][i+3]  <= (w5_q[i] == '0);
      aw7_q[i]      <= aw6_q[i];
      blw7_q[i]     <= mdf_pkg::bit_len({24'b0, aw6_q[i]});
      mw8_q[i]      <= mdf_pkg::norm32({24'b0, aw7_q[i]}, blw7_q[i]);
      ew8_q[i]      <= mdf_pkg::expo(blw7_q[i]);
      pf9_q[i]      <= lt_q[7].mp * mw8_q[i];
      xp9_q[i]      <= xp9_c[i];
      pf10_q[i]     <= pf9_q[i];
      blf10_q[i]    <= mdf_pkg::bit_len(pf9_q[i]);
      xp10_q[i]     <= xp9_q[i];
      mf11_q[i]     <= mdf_pkg::norm32(pf10_q[i], blf10_q[i]);
      x11_q[i]      <= xp10_q[i] + 10'(mdf_pkg::expo(blf10_q[i]));
      mag12_q[i]    <= mag_c[i][47:0];
      sat12_q[i]    <= sat_c[i];
    end
    field_q.field_x   <= fld_c[0];
    field_q.field_y   <= fld_c[1];
    field_q.field_z   <= fld_c[2];
    field_q.saturated <= live_c && |(sat12_q & ~wf_q[6][5:3]);
    field_q.singular  <= lt_q[11].sing;
  end

  always_comb begin
    live_c = !lt_q[11].sing && !lt_q[11].gz;
    for (int i = 0; i < 3; i++) begin
      if (!live_c || wf_q[6][i+3]) fld_c[i] = '0;
      else if (wf_q[6][i]) fld_c[i] = -mag12_q[i];
      else fld_c[i] = mag12_q[i];
    end
  end

  assign done_o  = vld_q[mdf_pkg::LATENCY-1];
  assign field_o = field_q;

endmodule

`default_nettype wire
